[hw/rtl/imdu_pkg.sv]
// shared types and constants for the integer multiply/divide unit
package imdu_pkg;

  // operand word width
  localparam int XLEN = 32;
  // width of the per-bit step counter
  localparam int CNT_W = $clog2(XLEN);

  // operation codes
  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new request and set up the operands
    logic step;  // one shift-add or shift-subtract iteration
    logic fix;   // sign fix-up and write of the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;  // the current iteration is the final one
  } status_t;

endpackage

[hw/rtl/imdu_datapath.sv]
// datapath: operand setup, shift-add multiplier, restoring divider, sign fix-up
module imdu_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  imdu_pkg::cmd_t              cmd,
  output imdu_pkg::status_t           status,
  input  logic [2:0]                  req_type,
  input  logic [imdu_pkg::XLEN-1:0]   operand_a,
  input  logic [imdu_pkg::XLEN-1:0]   operand_b,
  output logic [imdu_pkg::XLEN-1:0]   result
);

  localparam int W = imdu_pkg::XLEN;

  // working registers
  logic [W:0]                    hi;
  logic [W-1:0]                  lo;
  logic [W-1:0]                  dvsr;
  logic [imdu_pkg::CNT_W-1:0]    cnt;
  logic                          op_mul;
  logic                          sel_hi;
  logic                          neg_res;

  // request decode
  logic         a_signed;
  logic         b_signed;
  logic         dec_sel_hi;
  logic         a_neg;
  logic         b_neg;
  logic         b_zero;
  logic         dec_neg;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  always_comb begin
    a_signed   = 1'b0;
    b_signed   = 1'b0;
    dec_sel_hi = 1'b0;
    unique case (imdu_pkg::op_t'(req_type))
      imdu_pkg::OP_MUL: begin
      end
      imdu_pkg::OP_MULH: begin
        a_signed   = 1'b1;
        b_signed   = 1'b1;
        dec_sel_hi = 1'b1;
      end
      imdu_pkg::OP_MULHSU: begin
        a_signed   = 1'b1;
        dec_sel_hi = 1'b1;
      end
      imdu_pkg::OP_MULHU: begin
        dec_sel_hi = 1'b1;
      end
      imdu_pkg::OP_DIV: begin
        a_signed = 1'b1;
        b_signed = 1'b1;
      end
      imdu_pkg::OP_DIVU: begin
      end
      imdu_pkg::OP_REM: begin
        a_signed   = 1'b1;
        b_signed   = 1'b1;
        dec_sel_hi = 1'b1;
      end
      imdu_pkg::OP_REMU: begin
        dec_sel_hi = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // operand magnitudes and result sign
  always_comb begin
    a_neg  = a_signed & operand_a[W-1];
    b_neg  = b_signed & operand_b[W-1];
    b_zero = (operand_b == '0);
    mag_a  = a_neg ? (~operand_a + W'(1)) : operand_a;
    mag_b  = b_neg ? (~operand_b + W'(1)) : operand_b;
    if (!req_type[2]) begin
      dec_neg = a_neg ^ b_neg;
    end else if (dec_sel_hi) begin
      // remainder follows the dividend
      dec_neg = a_neg;
    end else begin
      // quotient of a zero divisor stays all ones
      dec_neg = (a_neg ^ b_neg) & ~b_zero;
    end
  end

  // one iteration of multiply or divide
  logic [W:0]   mul_sum;
  logic [W:0]   div_shift;
  logic [W:0]   div_diff;
  logic [W:0]   hi_step;
  logic [W-1:0] lo_step;

  always_comb begin
    mul_sum   = hi + (lo[0] ? {1'b0, dvsr} : '0);
    div_shift = {hi[W-1:0], lo[W-1]};
    div_diff  = div_shift - {1'b0, dvsr};
    if (op_mul) begin
      hi_step = {1'b0, mul_sum[W:1]};
      lo_step = {mul_sum[0], lo[W-1:1]};
    end else if (!div_diff[W]) begin
      hi_step = {1'b0, div_diff[W-1:0]};
      lo_step = {lo[W-2:0], 1'b1};
    end else begin
      hi_step = div_shift;
      lo_step = {lo[W-2:0], 1'b0};
    end
  end

  // sign fix-up: full product negate for multiply, single word for divide
  logic [2*W-1:0] prod;
  logic [2*W-1:0] prod_fix;
  logic [W-1:0]   word;
  logic [W-1:0]   word_fix;

  always_comb begin
    prod     = {hi[W-1:0], lo};
    prod_fix = neg_res ? (~prod + (2*W)'(1)) : prod;
    word     = sel_hi ? hi[W-1:0] : lo;
    word_fix = neg_res ? (~word + W'(1)) : word;
  end

  assign status.last = (cnt == imdu_pkg::CNT_W'(W - 1));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + imdu_pkg::CNT_W'(1);
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mul  <= ~req_type[2];
      sel_hi  <= dec_sel_hi;
      neg_res <= dec_neg;
      dvsr    <= mag_b;
      hi      <= '0;
      lo      <= mag_a;
    end else if (cmd.step) begin
      hi <= hi_step;
      lo <= lo_step;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      if (op_mul) begin
        result <= sel_hi ? prod_fix[2*W-1:W] : prod_fix[W-1:0];
      end else begin
        result <= word_fix;
      end
    end
  end

endmodule

[hw/rtl/imdu_ctrl.sv]
// controller: request handshake, iteration sequencing and result handshake
module imdu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output imdu_pkg::cmd_t      cmd,
  input  imdu_pkg::status_t   status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIX  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  // commands to the datapath
  always_comb begin
    cmd.load = (state == S_IDLE) & in_valid;
    cmd.step = (state == S_RUN);
    cmd.fix  = (state == S_FIX) & (~out_valid | ~out_stall);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (status.last) state_next = S_FIX;
      end
      S_FIX: begin
        if (cmd.fix) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.fix) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RUN))
    else $error("accepted request did not start iterating");

  a_last_goes_fix: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && status.last) |=> (state == S_FIX))
    else $error("final iteration not followed by fix-up");

  a_fix_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |=> (out_valid && state == S_IDLE))
    else $error("fix-up did not present a result");
`endif

endmodule

[hw/rtl/integer_mul_div_unit_core.sv]
// top level of the integer multiply/divide unit
// Computes one 32-bit multiply, multiply-high, divide or remainder request at a
// time. A request is taken when the unit is idle; it then processes one operand
// bit per cycle through a shared shift-add / restoring-subtract datapath, then
// a sign fix-up step writes the result register; the fix-up waits while a
// previous result is still valid and stalled. The unit then returns to idle and
// only then takes the next request.
// The finished result sits in its own register, so the next request starts
// while the last result is still waiting to be taken. Division by zero gives
// all ones (quotient) or the dividend (remainder); the most negative value
// divided by -1 gives itself as quotient and zero as remainder.
module integer_mul_div_unit_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic [imdu_pkg::XLEN-1:0]   operand_a,
  input  logic [imdu_pkg::XLEN-1:0]   operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [imdu_pkg::XLEN-1:0]   result
);

  imdu_pkg::cmd_t    cmd;
  imdu_pkg::status_t status;

  // sequencing
  imdu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic
  imdu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .result    (result)
  );

endmodule

[test/integer_mul_div_unit_core_tb.sv]
// self-checking testbench for the integer multiply/divide unit: directed table, random requests
`timescale 1ns / 1ps

module integer_mul_div_unit_core_tb;
  import imdu_pkg::*;

  localparam int W = XLEN;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int DIRECTED_ROWS = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = W + 8;

  // receiver stall patterns
  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_SPARSE = 2'd1;
  localparam logic [1:0] STALL_LONG   = 2'd2;
  localparam logic [1:0] STALL_TOGGLE = 2'd3;

  typedef logic [W-1:0] word_t;

  // one row of the directed table; known rows carry their answer
  typedef struct packed {
    op_t   op;
    word_t a;
    word_t b;
    logic  known;
    word_t answer;
  } dir_row_t;

  // one outstanding request and the value it must produce
  typedef struct {
    op_t   op;
    word_t a;
    word_t b;
    word_t value;
  } mdu_expect_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] req_type;
  word_t      operand_a;
  word_t      operand_b;
  logic       out_valid;
  logic       out_stall;
  word_t      result;

  mdu_expect_t pending_results[$];
  dir_row_t    directed_rows [0:DIRECTED_ROWS-1];
  int          error_count = 0;
  int          checked_count = 0;
  int          div_zero_count;
  int          cycle_count = 0;
  int          stall_hold;

  integer_mul_div_unit_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // m extension result for one request
  function automatic word_t m_ext_result(op_t op, word_t a, word_t b);
    logic [2*W-1:0] prod_ss;
    logic [2*W-1:0] prod_su;
    logic [2*W-1:0] prod_uu;
    word_t          mag_a;
    word_t          mag_b;
    word_t          quot;
    word_t          rem;
    prod_ss = {{W{a[W-1]}}, a} * {{W{b[W-1]}}, b};
    prod_su = {{W{a[W-1]}}, a} * {{W{1'b0}}, b};
    prod_uu = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    mag_a = a[W-1] ? -a : a;
    mag_b = b[W-1] ? -b : b;
    quot = (mag_b == '0) ? '0 : mag_a / mag_b;
    rem = (mag_b == '0) ? '0 : mag_a % mag_b;
    case (op)
      OP_MUL:    return prod_uu[W-1:0];
      OP_MULH:   return prod_ss[2*W-1:W];
      OP_MULHSU: return prod_su[2*W-1:W];
      OP_MULHU:  return prod_uu[2*W-1:W];
      OP_DIV: begin
        if (b == '0) return '1;
        return (a[W-1] != b[W-1]) ? -quot : quot;
      end
      OP_DIVU:   return (b == '0) ? '1 : a / b;
      OP_REM: begin
        if (b == '0) return a;
        return a[W-1] ? -rem : rem;
      end
      default:   return (b == '0) ? a : a % b;
    endcase
  endfunction

  // operand biased toward edge values
  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return {1'b1, {(W-1){1'b0}}};
      4:       return {1'b0, {(W-1){1'b1}}};
      5:       return word_t'($urandom_range(0, 15));
      6:       return -word_t'($urandom_range(1, 16));
      default: return word_t'($urandom);
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_request(op_t op, word_t a, word_t b, word_t value);
    mdu_expect_t entry;
    in_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry.op = op;
    entry.a = a;
    entry.b = b;
    entry.value = value;
    pending_results.push_back(entry);
    if (b == '0 && op >= OP_DIV) div_zero_count++;
  endtask

  // sender gap of a given length
  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding request has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    mdu_expect_t head;
    if (rst) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          head = pending_results.pop_front();
          checked_count++;
          if (result !== head.value) begin
            $display("%0t: mismatch %s a=%h b=%h expected %h actual %h", $time,
                     head.op.name(), head.a, head.b, head.value, result);
            error_count++;
          end
        end
      end
      case (cycle_count[10:9])
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_LONG: begin
          if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 15) == 0) stall_hold <= $urandom_range(1, 40);
          end
        end
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  // stimulus
  initial begin
    int   burst_left;
    op_t  op;
    word_t a;
    word_t b;
    div_zero_count = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= OP_MUL;
    operand_a <= '0;
    operand_b <= '0;

    // edge values, every operation, divide by zero, signed overflow
    directed_rows = '{
      '{OP_MUL,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_MUL,    32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0001},
      '{OP_MUL,    32'h7fff_ffff, 32'h0000_0002, 1'b1, 32'hffff_fffe},
      '{OP_MULH,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_MULH,   32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000},
      '{OP_MULH,   32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{OP_MULHSU, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
      '{OP_MULHSU, 32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{OP_MULHU,  32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_fffe},
      '{OP_MULHU,  32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0001},
      '{OP_DIV,    32'h0000_1234, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_DIV,    32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000},
      '{OP_DIV,    32'hffff_fff9, 32'h0000_0002, 1'b1, 32'hffff_fffd},
      '{OP_DIV,    32'h0000_0007, 32'hffff_fffe, 1'b0, 32'h0000_0000},
      '{OP_DIVU,   32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_DIVU,   32'hffff_ffff, 32'h0000_0001, 1'b1, 32'hffff_ffff},
      '{OP_DIVU,   32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_REM,    32'h0000_1234, 32'h0000_0000, 1'b1, 32'h0000_1234},
      '{OP_REM,    32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_REM,    32'hffff_fff9, 32'h0000_0002, 1'b1, 32'hffff_ffff},
      '{OP_REM,    32'h0000_0007, 32'hffff_fffe, 1'b0, 32'h0000_0000},
      '{OP_REMU,   32'h89ab_cdef, 32'h0000_0000, 1'b1, 32'h89ab_cdef},
      '{OP_REMU,   32'hffff_ffff, 32'h0000_0010, 1'b1, 32'h0000_000f},
      '{OP_REMU,   32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, one gap pattern per row
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].known ? directed_rows[i].answer
                   : m_ext_result(directed_rows[i].op, directed_rows[i].a,
                                  directed_rows[i].b));
      idle_cycles(i % 4);
    end
    drain_results();

    // random requests in bursts, with gap-free stretches
    burst_left = 0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ((i / 200) % 2 == 1) idle_cycles(0);
        else idle_cycles($urandom_range(0, 20));
      end
      burst_left--;
      op = op_t'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      send_request(op, a, b, m_ext_result(op, a, b));
    end

    // wait out the last results, then a few more cycles for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d directed and %0d random requests over all eight operations",
             DIRECTED_ROWS, RANDOM_REQUESTS);
    $display("%0d results checked, %0d divides by zero, %0d errors",
             checked_count, div_zero_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
